>>> rtl/oriented_rectangle_overlap_check_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle overlap check unit
// Shorthand for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_RECTANGLE_OVERLAP_CHECK_UNIT_DEFINES_SVH
`define ORIENTED_RECTANGLE_OVERLAP_CHECK_UNIT_DEFINES_SVH

// Check that cons holds in the cycle in which ante holds.
`define ORC_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ORC_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/orc_pkg.sv
// ----------------------------------------------------------------------------
// orc_pkg
// Shared constants, codes and types of the rectangle overlap check unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package orc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_FRAC_DEF  = 16;
    localparam int SIZE_BITS      = 16;
    localparam int CORDIC_STEPS   = 28;
    localparam int CORDIC_FRAC    = 30;
    localparam int CFG_IDX_BITS   = 3;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_HEADING  = 3'd2,
        CFG_LENGTH   = 3'd3,
        CFG_WIDTH    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic vld;
        logic tok;
        logic func;
    } t_ctl;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/orc_cordic.sv
// ----------------------------------------------------------------------------
// orc_cordic
// Pipelined rotation CORDIC: one micro-rotation per stage, then rounding,
// clamping and quadrant mapping to cosine and sine. Pose data rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orc_cordic #(
    parameter int COORD_BITS     = orc_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS     = orc_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = orc_pkg::TRIG_FRAC_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  orc_pkg::t_ctl                         i_ctl,
    output logic                                  o_rdy,
    input  wire  [ANGLE_BITS-1:0]                 i_angle,
    input  wire  signed [COORD_BITS-1:0]          i_px,
    input  wire  signed [COORD_BITS-1:0]          i_py,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_len,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_wid,
    output orc_pkg::t_ctl                         o_ctl,
    input  wire                                   i_rdy,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_cos,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_sin,
    output logic signed [COORD_BITS-1:0]          o_px,
    output logic signed [COORD_BITS-1:0]          o_py,
    output logic [orc_pkg::SIZE_BITS-1:0]         o_len,
    output logic [orc_pkg::SIZE_BITS-1:0]         o_wid
);
    import orc_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int NS = N + 2;
    localparam int XW = CORDIC_FRAC + 3;
    localparam int ZW = CORDIC_FRAC + 2;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam logic signed [XW-1:0] RND = XW'(64'd1 << (SH - 1));
    localparam logic signed [XW-1:0] ONE = XW'(64'd1 << TRIG_FRAC_BITS);

    logic [NS:0] rdy;
    t_ctl        r_ctl [NS];

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];

    logic signed [COORD_BITS-1:0] r_px  [NS];
    logic signed [COORD_BITS-1:0] r_py  [NS];
    logic [SIZE_BITS-1:0]         r_len [NS];
    logic [SIZE_BITS-1:0]         r_wid [NS];

    logic signed [TW-1:0] r_cos, r_sin;
    logic signed [TW-1:0] n_cos, n_sin;
    logic signed [XW-1:0] n_cr, n_sr;
    logic signed [TW-1:0] n_c, n_s;
    logic signed [ZW-1:0] n_z0;

    assign rdy[NS] = i_rdy;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !r_ctl[k].vld || rdy[k+1];
    end
    assign o_rdy = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_ctl[k] <= '0;
        end else begin
            if (rdy[0]) r_ctl[0] <= i_ctl;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_px[0]  <= i_px;
            r_py[0]  <= i_py;
            r_len[0] <= i_len;
            r_wid[0] <= i_wid;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                r_px[k]  <= r_px[k-1];
                r_py[k]  <= r_py[k-1];
                r_len[k] <= r_len[k-1];
                r_wid[k] <= r_wid[k-1];
            end
        end
    end

    assign n_z0 = $signed(ZW'({i_angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_x[0] <= XW'(CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_q[0] <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_it
        logic signed [XW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_z;
        always_comb begin
            if (!r_z[k-1][ZW-1]) begin
                n_x = r_x[k-1] - (r_y[k-1] >>> (k - 1));
                n_y = r_y[k-1] + (r_x[k-1] >>> (k - 1));
                n_z = r_z[k-1] - $signed(ZW'(atan_turn(k - 1)));
            end else begin
                n_x = r_x[k-1] + (r_y[k-1] >>> (k - 1));
                n_y = r_y[k-1] - (r_x[k-1] >>> (k - 1));
                n_z = r_z[k-1] + $signed(ZW'(atan_turn(k - 1)));
            end
        end
        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
                r_q[k] <= r_q[k-1];
            end
        end
    end

    always_comb begin
        n_cr = (r_x[N] + RND) >>> SH;
        n_sr = (r_y[N] + RND) >>> SH;
        if (n_cr > ONE)       n_c = TW'(ONE);
        else if (n_cr < -ONE) n_c = TW'(-ONE);
        else                  n_c = TW'(n_cr);
        if (n_sr > ONE)       n_s = TW'(ONE);
        else if (n_sr < -ONE) n_s = TW'(-ONE);
        else                  n_s = TW'(n_sr);
        case (r_q[N])
            2'd0: begin
                n_cos = n_c;
                n_sin = n_s;
            end
            2'd1: begin
                n_cos = -n_s;
                n_sin = n_c;
            end
            2'd2: begin
                n_cos = -n_c;
                n_sin = -n_s;
            end
            default: begin
                n_cos = n_s;
                n_sin = -n_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_ctl = r_ctl[NS-1];
    assign o_cos = r_cos;
    assign o_sin = r_sin;
    assign o_px  = r_px[NS-1];
    assign o_py  = r_py[NS-1];
    assign o_len = r_len[NS-1];
    assign o_wid = r_wid[NS-1];

endmodule

`default_nettype wire

>>> rtl/orc_corners.sv
// ----------------------------------------------------------------------------
// orc_corners
// Half-size offsets from cosine and sine, then the four saturated corners
// around the center. A point test passes its point as corner zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orc_corners #(
    parameter int COORD_BITS     = orc_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = orc_pkg::TRIG_FRAC_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  orc_pkg::t_ctl                         i_ctl,
    output logic                                  o_rdy,
    input  wire  signed [TRIG_FRAC_BITS+1:0]      i_cos,
    input  wire  signed [TRIG_FRAC_BITS+1:0]      i_sin,
    input  wire  signed [COORD_BITS-1:0]          i_px,
    input  wire  signed [COORD_BITS-1:0]          i_py,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_len,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_wid,
    output orc_pkg::t_ctl                         o_ctl,
    input  wire                                   i_rdy,
    output logic signed [COORD_BITS-1:0]          o_cx [4],
    output logic signed [COORD_BITS-1:0]          o_cy [4]
);
    import orc_pkg::*;

    localparam int NS = 3;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = SIZE_BITS + 1 + TW;
    localparam int HW = SIZE_BITS + 2;
    localparam int SW = COORD_BITS + 2;
    localparam logic signed [PW-1:0] HRND = PW'(64'd1 << TRIG_FRAC_BITS);
    localparam logic signed [SW-1:0] CMAX = SW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

    logic [NS:0] rdy;
    t_ctl        r_ctl [NS];

    logic signed [COORD_BITS-1:0] r_px [2];
    logic signed [COORD_BITS-1:0] r_py [2];

    logic signed [PW-1:0] r_lc, r_ls, r_ws, r_wc;
    logic signed [PW-1:0] n_lc, n_ls, n_ws, n_wc;
    logic signed [HW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [HW-1:0] n_ax, n_ay, n_bx, n_by;
    logic signed [COORD_BITS-1:0] r_cx [4];
    logic signed [COORD_BITS-1:0] r_cy [4];
    logic signed [COORD_BITS-1:0] n_cx [4];
    logic signed [COORD_BITS-1:0] n_cy [4];
    logic signed [SW-1:0] n_x, n_y, n_ax2, n_ay2, n_bx2, n_by2;

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > CMAX)      r = COORD_BITS'(CMAX);
        else if (v < CMIN) r = COORD_BITS'(CMIN);
        else               r = COORD_BITS'(v);
        return r;
    endfunction

    assign rdy[NS] = i_rdy;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !r_ctl[k].vld || rdy[k+1];
    end
    assign o_rdy = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_ctl[k] <= '0;
        end else begin
            if (rdy[0]) r_ctl[0] <= i_ctl;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_comb begin
        n_lc = $signed({1'b0, i_len}) * i_cos;
        n_ls = $signed({1'b0, i_len}) * i_sin;
        n_ws = $signed({1'b0, i_wid}) * i_sin;
        n_wc = $signed({1'b0, i_wid}) * i_cos;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_lc    <= n_lc;
            r_ls    <= n_ls;
            r_ws    <= n_ws;
            r_wc    <= n_wc;
            r_px[0] <= i_px;
            r_py[0] <= i_py;
        end
    end

    always_comb begin
        n_ax = HW'((r_lc + HRND) >>> (TRIG_FRAC_BITS + 1));
        n_ay = HW'((r_ls + HRND) >>> (TRIG_FRAC_BITS + 1));
        n_bx = HW'((r_ws + HRND) >>> (TRIG_FRAC_BITS + 1));
        n_by = HW'((r_wc + HRND) >>> (TRIG_FRAC_BITS + 1));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_px[1] <= r_px[0];
            r_py[1] <= r_py[0];
        end
    end

    always_comb begin
        n_x   = SW'(r_px[1]);
        n_y   = SW'(r_py[1]);
        n_ax2 = SW'(r_ax);
        n_ay2 = SW'(r_ay);
        n_bx2 = SW'(r_bx);
        n_by2 = SW'(r_by);
        n_cx[0] = r_ctl[1].func ? sat(n_x + n_ax2 - n_bx2) : r_px[1];
        n_cy[0] = r_ctl[1].func ? sat(n_y + n_ay2 + n_by2) : r_py[1];
        n_cx[1] = sat(n_x - n_ax2 - n_bx2);
        n_cy[1] = sat(n_y - n_ay2 + n_by2);
        n_cx[2] = sat(n_x - n_ax2 + n_bx2);
        n_cy[2] = sat(n_y - n_ay2 - n_by2);
        n_cx[3] = sat(n_x + n_ax2 + n_bx2);
        n_cy[3] = sat(n_y + n_ay2 - n_by2);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= n_cx[k];
                r_cy[k] <= n_cy[k];
            end
        end
    end

    assign o_ctl = r_ctl[NS-1];
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;

endmodule

`default_nettype wire

>>> rtl/orc_inside.sv
// ----------------------------------------------------------------------------
// orc_inside
// Eight point-in-rectangle tests in parallel: edge and offset vectors,
// exact cross products, signs, then the combined hit flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orc_inside #(
    parameter int COORD_BITS = orc_pkg::COORD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  orc_pkg::t_ctl                 i_ctl,
    output logic                          o_rdy,
    input  wire  signed [COORD_BITS-1:0]  i_own_x [4],
    input  wire  signed [COORD_BITS-1:0]  i_own_y [4],
    input  wire  signed [COORD_BITS-1:0]  i_oth_x [4],
    input  wire  signed [COORD_BITS-1:0]  i_oth_y [4],
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic                          o_hit
);
    import orc_pkg::*;

    localparam int NS = 4;
    localparam int DW = COORD_BITS + 1;
    localparam int MW = 2 * DW;

    logic [NS:0] rdy;
    t_ctl        r_ctl [NS];

    logic signed [DW-1:0] r_ex [8][4];
    logic signed [DW-1:0] r_ey [8][4];
    logic signed [DW-1:0] r_dx [8][4];
    logic signed [DW-1:0] r_dy [8][4];
    logic signed [MW-1:0] r_m1 [8][4];
    logic signed [MW-1:0] r_m2 [8][4];
    logic [3:0]           r_pos [8];
    logic [3:0]           r_neg [8];
    logic [7:0]           n_ins;
    logic                 r_hit;

    assign rdy[NS] = !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !r_ctl[k].vld || rdy[k+1];
    end
    assign o_rdy = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_ctl[k] <= '0;
        end else begin
            if (rdy[0]) r_ctl[0] <= i_ctl;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    for (genvar t = 0; t < 8; t++) begin : g_test
        for (genvar e = 0; e < 4; e++) begin : g_edge
            logic signed [COORD_BITS-1:0] n_ax, n_ay, n_bx, n_by, n_px, n_py;
            logic signed [MW:0] n_cr;
            always_comb begin
                if (t < 4) begin
                    n_ax = i_own_x[e];
                    n_ay = i_own_y[e];
                    n_bx = i_own_x[(e + 1) % 4];
                    n_by = i_own_y[(e + 1) % 4];
                    n_px = i_oth_x[t % 4];
                    n_py = i_oth_y[t % 4];
                end else begin
                    n_ax = i_oth_x[e];
                    n_ay = i_oth_y[e];
                    n_bx = i_oth_x[(e + 1) % 4];
                    n_by = i_oth_y[(e + 1) % 4];
                    n_px = i_own_x[t % 4];
                    n_py = i_own_y[t % 4];
                end
            end
            always_ff @(posedge i_clk) begin
                if (rdy[0]) begin
                    r_ex[t][e] <= DW'(n_bx) - DW'(n_ax);
                    r_ey[t][e] <= DW'(n_by) - DW'(n_ay);
                    r_dx[t][e] <= DW'(n_px) - DW'(n_ax);
                    r_dy[t][e] <= DW'(n_py) - DW'(n_ay);
                end
                if (rdy[1]) begin
                    r_m1[t][e] <= r_ex[t][e] * r_dy[t][e];
                    r_m2[t][e] <= r_ey[t][e] * r_dx[t][e];
                end
                if (rdy[2]) begin
                    r_pos[t][e] <= !n_cr[MW] && (n_cr != '0);
                    r_neg[t][e] <= n_cr[MW];
                end
            end
            assign n_cr = (MW + 1)'(r_m1[t][e]) - (MW + 1)'(r_m2[t][e]);
        end
        assign n_ins[t] = !((|r_pos[t]) && (|r_neg[t]));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) r_hit <= n_ins[0] || (r_ctl[2].func && (|n_ins[7:1]));
    end

    assign o_valid = r_ctl[NS-1].vld;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

>>> rtl/oriented_rectangle_overlap_check_unit.sv
// ----------------------------------------------------------------------------
// oriented_rectangle_overlap_check_unit
// Tests points and oriented rectangles against one configured rectangle.
// ----------------------------------------------------------------------------
// Input words (i_valid / o_stall) carry a point test or a rectangle pose; each
// gives one output word (o_valid / i_stall) with o_hit. A word is taken at an
// edge with valid high and stall low.
// There are 30 CORDIC stages, 3 corner stages and 4 test stages, the last
// being the output register. One word enters every cycle while o_stall is
// low. Configuration writes use i_cfg_valid / o_cfg_ready. Each accepted
// write to one of the five configuration registers sends a rebuild word for
// the own rectangle down the CORDIC and corner stages; o_cfg_ready stays low
// and o_stall high until the own corners are updated.
// A stalled output holds its word; earlier stages keep filling empty slots,
// so input is taken until the pipeline is full.
// Synchronous reset clears all valid bits, the configuration registers and the own corners.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oriented_rectangle_overlap_check_unit #(
    parameter int COORD_BITS     = orc_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS     = orc_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = orc_pkg::TRIG_FRAC_DEF,
    localparam int CFG_BITS      = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire                                   i_func,
    input  wire  signed [COORD_BITS-1:0]          i_pos_x,
    input  wire  signed [COORD_BITS-1:0]          i_pos_y,
    input  wire  [ANGLE_BITS-1:0]                 i_heading,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_length,
    input  wire  [orc_pkg::SIZE_BITS-1:0]         i_width,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic                                  o_hit,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [orc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [CFG_BITS-1:0]                   i_cfg_data
);
    import orc_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;

    logic signed [COORD_BITS-1:0] r_cen_x, r_cen_y;
    logic [ANGLE_BITS-1:0]        r_hdg;
    logic [SIZE_BITS-1:0]         r_len, r_wid;
    logic                         r_busy, r_pend;
    logic signed [COORD_BITS-1:0] r_own_x [4];
    logic signed [COORD_BITS-1:0] r_own_y [4];

    logic                         n_busy, n_pend, n_rebuild;
    logic                         cfg_wr;

    t_ctl                         cd_in_ctl, cd_out_ctl, cn_out_ctl, in_ctl;
    logic                         cd_rdy, cn_rdy, in_rdy, cn_dn_rdy;
    logic [ANGLE_BITS-1:0]        cd_angle;
    logic signed [COORD_BITS-1:0] cd_px, cd_py, cn_px, cn_py;
    logic [SIZE_BITS-1:0]         cd_len, cd_wid, cn_len, cn_wid;
    logic signed [TW-1:0]         cn_cos, cn_sin;
    logic signed [COORD_BITS-1:0] cn_cx [4];
    logic signed [COORD_BITS-1:0] cn_cy [4];

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !r_busy;
    assign o_stall     = r_busy || !cd_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen_x <= '0;
            r_cen_y <= '0;
            r_hdg   <= '0;
            r_len   <= '0;
            r_wid   <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_cen_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y: r_cen_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_HEADING:  r_hdg   <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_LENGTH:   r_len   <= i_cfg_data[SIZE_BITS-1:0];
                CFG_WIDTH:    r_wid   <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cfg_index)
            CFG_CENTER_X, CFG_CENTER_Y, CFG_HEADING, CFG_LENGTH, CFG_WIDTH:
                n_rebuild = cfg_wr;
            default:
                n_rebuild = 1'b0;
        endcase
        n_pend = r_pend;
        n_busy = r_busy;
        if (r_pend && cd_rdy) n_pend = 1'b0;
        if (cn_out_ctl.vld && cn_out_ctl.tok) n_busy = 1'b0;
        if (n_rebuild) begin
            n_pend = 1'b1;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_own_x[k] <= '0;
                r_own_y[k] <= '0;
            end
        end else if (cn_out_ctl.vld && cn_out_ctl.tok) begin
            r_own_x <= cn_cx;
            r_own_y <= cn_cy;
        end
    end

    always_comb begin
        cd_in_ctl.vld  = r_pend || (i_valid && !r_busy);
        cd_in_ctl.tok  = r_pend;
        cd_in_ctl.func = r_pend || i_func;
        cd_angle       = r_pend ? r_hdg   : i_heading;
        cd_px          = r_pend ? r_cen_x : i_pos_x;
        cd_py          = r_pend ? r_cen_y : i_pos_y;
        cd_len         = r_pend ? r_len   : i_length;
        cd_wid         = r_pend ? r_wid   : i_width;
    end

    orc_cordic #(
        .COORD_BITS     (COORD_BITS),
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cd_in_ctl),
        .o_rdy   (cd_rdy),
        .i_angle (cd_angle),
        .i_px    (cd_px),
        .i_py    (cd_py),
        .i_len   (cd_len),
        .i_wid   (cd_wid),
        .o_ctl   (cd_out_ctl),
        .i_rdy   (cn_rdy),
        .o_cos   (cn_cos),
        .o_sin   (cn_sin),
        .o_px    (cn_px),
        .o_py    (cn_py),
        .o_len   (cn_len),
        .o_wid   (cn_wid)
    );

    orc_corners #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_corners (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cd_out_ctl),
        .o_rdy   (cn_rdy),
        .i_cos   (cn_cos),
        .i_sin   (cn_sin),
        .i_px    (cn_px),
        .i_py    (cn_py),
        .i_len   (cn_len),
        .i_wid   (cn_wid),
        .o_ctl   (cn_out_ctl),
        .i_rdy   (cn_dn_rdy),
        .o_cx    (cn_cx),
        .o_cy    (cn_cy)
    );

    // drop rebuild words here; they only refresh the own corners
    assign cn_dn_rdy = cn_out_ctl.tok || in_rdy;
    always_comb begin
        in_ctl     = cn_out_ctl;
        in_ctl.vld = cn_out_ctl.vld && !cn_out_ctl.tok;
    end

    orc_inside #(
        .COORD_BITS (COORD_BITS)
    ) u_inside (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .o_rdy   (in_rdy),
        .i_own_x (r_own_x),
        .i_own_y (r_own_y),
        .i_oth_x (cn_cx),
        .i_oth_y (cn_cy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hit   (o_hit)
    );

endmodule

`default_nettype wire

>>> rtl/orc_checker.sv
// ----------------------------------------------------------------------------
// orc_checker
// Port-level checks of the overlap check unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "oriented_rectangle_overlap_check_unit_defines.svh"

module orc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_stall,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire                              o_hit,
    input wire                              i_cfg_valid,
    input wire                              o_cfg_ready,
    input wire [orc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index
);

    `ORC_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_hit), "output word changed")
    `ORC_ASSERT_NXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_valid, "output valid after reset")
    `ORC_ASSERT_NXT(a_cfg_block, i_clk, !i_rst_n, i_cfg_valid && o_cfg_ready && (i_cfg_index <= orc_pkg::CFG_WIDTH), o_stall, "input open in rebuild")
    `ORC_ASSERT_IMP(a_busy_stall, i_clk, !i_rst_n, !o_cfg_ready, o_stall, "input open while busy")

endmodule

bind oriented_rectangle_overlap_check_unit orc_checker u_orc_checker (.*);

`default_nettype wire

>>> tb/oriented_rectangle_overlap_check_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap check unit checker
// Watches the input, output and configuration channels, predicts the hit bit
// of every accepted input word and compares it with the output words in order.
// ----------------------------------------------------------------------------
module oriented_rectangle_overlap_check_unit_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        o_stall,
    input  wire        i_func,
    input  wire [23:0] i_pos_x,
    input  wire [23:0] i_pos_y,
    input  wire [15:0] i_heading,
    input  wire [15:0] i_length,
    input  wire [15:0] i_width,
    input  wire        o_valid,
    input  wire        i_stall,
    input  wire        o_hit,
    input  wire        i_cfg_valid,
    input  wire        o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [23:0] i_cfg_data,
    output int         n_fail,
    output int         n_pending
);
    import orc_pkg::*;

    typedef longint t_quad[8];

    logic [23:0] cx_reg, cy_reg;
    logic [15:0] hd_reg, len_reg, wid_reg;
    t_quad       own_quad;
    bit          hit_q[$];

    function automatic longint sat24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint round_trig(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 13)) >>> 14;
        if (r > 64'sd65536) r = 64'sd65536;
        if (r < -64'sd65536) r = -64'sd65536;
        return r;
    endfunction

    function automatic void sin_cos(input logic [15:0] h, output longint cs, output longint sn);
        logic [31:0] a;
        longint      x, y, z, dx, dy, c, s;
        a = {h, 16'd0};
        z = longint'(a[29:0]);
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        c = round_trig(x);
        s = round_trig(y);
        case (a[31:30])
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic longint half_extent(input longint sz, input longint t);
        return (sz * t + (64'sd1 <<< 16)) >>> 17;
    endfunction

    function automatic void make_quad(input longint cx, input longint cy, input logic [15:0] h,
                                      input logic [15:0] l, input logic [15:0] w,
                                      output t_quad r);
        longint c, s, ax, ay, bx, by;
        sin_cos(h, c, s);
        ax = half_extent(longint'(l), c);
        ay = half_extent(longint'(l), s);
        bx = half_extent(longint'(w), s);
        by = half_extent(longint'(w), c);
        r[0] = sat24(cx + ax - bx); r[1] = sat24(cy + ay + by);
        r[2] = sat24(cx - ax - bx); r[3] = sat24(cy - ay + by);
        r[4] = sat24(cx - ax + bx); r[5] = sat24(cy - ay - by);
        r[6] = sat24(cx + ax + bx); r[7] = sat24(cy + ay - by);
    endfunction

    function automatic bit pt_in_quad(input t_quad r, input longint px, input longint py);
        bit     pos, neg;
        int     n;
        longint cr;
        pos = 0;
        neg = 0;
        for (int k = 0; k < 4; k++) begin
            n = (k + 1) % 4;
            cr = (r[2*n] - r[2*k]) * (py - r[2*k+1]) - (r[2*n+1] - r[2*k+1]) * (px - r[2*k]);
            if (cr > 0) pos = 1;
            if (cr < 0) neg = 1;
        end
        return !(pos && neg);
    endfunction

    function automatic bit predict_hit(input bit fn, input longint px, input longint py,
                                       input logic [15:0] h, input logic [15:0] l,
                                       input logic [15:0] w);
        t_quad other;
        bit    hit;
        if (!fn) return pt_in_quad(own_quad, px, py);
        make_quad(px, py, h, l, w, other);
        hit = 0;
        for (int k = 0; k < 4; k++) begin
            if (pt_in_quad(own_quad, other[2*k], other[2*k+1])) hit = 1;
            if (pt_in_quad(other, own_quad[2*k], own_quad[2*k+1])) hit = 1;
        end
        return hit;
    endfunction

    task automatic report(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        n_fail++;
    endtask

    initial begin
        n_fail = 0;
        n_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cx_reg = '0; cy_reg = '0; hd_reg = '0; len_reg = '0; wid_reg = '0;
            for (int k = 0; k < 8; k++) own_quad[k] = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= CFG_WIDTH) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTER_X: cx_reg = i_cfg_data;
                    CFG_CENTER_Y: cy_reg = i_cfg_data;
                    CFG_HEADING:  hd_reg = i_cfg_data[15:0];
                    CFG_LENGTH:   len_reg = i_cfg_data[15:0];
                    CFG_WIDTH:    wid_reg = i_cfg_data[15:0];
                    default: ;
                endcase
                make_quad(longint'($signed(cx_reg)), longint'($signed(cy_reg)),
                          hd_reg, len_reg, wid_reg, own_quad);
            end
            if (i_valid && !o_stall)
                hit_q.push_back(predict_hit(i_func, longint'($signed(i_pos_x)),
                                            longint'($signed(i_pos_y)),
                                            i_heading, i_length, i_width));
            if (o_valid && !i_stall) begin
                if (hit_q.size() == 0)
                    report("output word with no word expected");
                else if (hit_q[0] !== o_hit) begin
                    report($sformatf("hit %b, expected %b", o_hit, hit_q[0]));
                    void'(hit_q.pop_front());
                end else
                    void'(hit_q.pop_front());
            end
            n_pending <= hit_q.size();
        end
    end
endmodule

>>> tb/oriented_rectangle_overlap_check_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap check unit test
// Configures several own rectangles, streams directed and random point and
// rectangle tests with bursty input and stalled output, and gives the verdict.
// ----------------------------------------------------------------------------
module oriented_rectangle_overlap_check_unit_test;
    import orc_pkg::*;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0, i_func = 0;
    logic [23:0] i_pos_x = 0, i_pos_y = 0;
    logic [15:0] i_heading = 0, i_length = 0, i_width = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;
    wire         o_stall, o_valid, o_hit, o_cfg_ready;
    int          n_fail, n_pending;
    bit          hold_req = 0;
    int          own_x, own_y, own_span;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    oriented_rectangle_overlap_check_unit dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_pos_x, .i_pos_y,
        .i_heading, .i_length, .i_width, .o_valid, .i_stall, .o_hit,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    oriented_rectangle_overlap_check_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_pos_x, .i_pos_y,
        .i_heading, .i_length, .i_width, .o_valid, .i_stall, .o_hit,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data, .n_fail, .n_pending
    );

    // receiver stall pattern, with long hold-offs on request
    always @(posedge i_clk) begin
        int mode, cnt;
        if (hold_req) begin
            i_stall <= 1;
            cnt++;
            if (cnt >= 400) begin
                hold_req = 0;
                cnt = 0;
            end
        end else begin
            if ($urandom_range(63) == 0) mode = $urandom_range(3);
            case (mode)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(3) == 0);
                2: i_stall <= ($urandom_range(3) != 0);
                default: i_stall <= $urandom_range(1);
            endcase
        end
    end

    task automatic wait_drained();
        while (n_pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int cx, input int cy, input int hd, input int ln, input int wd);
        i_valid <= 0;
        wait_drained();
        write_reg(3'd5 + 3'($urandom_range(2)), 24'($urandom));
        write_reg(CFG_CENTER_X, 24'(cx));
        write_reg(CFG_CENTER_Y, 24'(cy));
        write_reg(CFG_HEADING, {8'($urandom), 16'(hd)});
        write_reg(CFG_LENGTH, {8'($urandom), 16'(ln)});
        write_reg(CFG_WIDTH, {8'($urandom), 16'(wd)});
        own_x = cx;
        own_y = cy;
        own_span = (ln > wd ? ln : wd) + 16;
    endtask

    task automatic send_word(input bit fn, input int px, input int py,
                             input int hd, input int ln, input int wd);
        i_valid <= 1;
        i_func <= fn;
        i_pos_x <= 24'(px);
        i_pos_y <= 24'(py);
        i_heading <= 16'(hd);
        i_length <= 16'(ln);
        i_width <= 16'(wd);
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        int px, py, r;
        r = $urandom_range(9);
        if (r < 7) begin
            px = own_x + $signed($urandom_range(2 * own_span)) - own_span;
            py = own_y + $signed($urandom_range(2 * own_span)) - own_span;
        end else begin
            px = $signed($urandom) >>> 8;
            py = $signed($urandom) >>> 8;
        end
        if ($urandom_range(3) == 0)
            send_word($urandom_range(1), px, py, $urandom, $urandom, $urandom);
        else
            send_word($urandom_range(1), px, py, $urandom, $urandom_range(own_span),
                      $urandom_range(own_span));
    endtask

    task automatic directed();
        send_word(0, own_x, own_y, 0, 0, 0);
        send_word(0, own_x + own_span, own_y, 65535, 65535, 65535);
        send_word(0, 8388607, -8388608, 0, 0, 0);
        send_word(0, -8388608, 8388607, 0, 0, 0);
        send_word(1, own_x, own_y, 0, 0, 0);
        send_word(1, own_x + 2 * own_span, own_y, 16384, 65535, 100);
        send_word(1, 8388607, 8388607, 32768, 65535, 65535);
        send_word(1, -8388608, -8388608, 65535, 0, 65535);
        send_word(1, own_x - own_span, own_y + own_span, 8192, own_span, 0);
        send_word(1, own_x, own_y + 3 * own_span, 49152, 1, 1);
    endtask

    initial begin
        int phase, burst, sent;
        own_x = 0;
        own_y = 0;
        own_span = 16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed();
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(0, 0, 0, 2560, 1024);
                1: configure(8388607, -8388608, 65535, 65535, 65535);
                2: configure(1000, -2000, 12345, 0, 800);
                3: configure(-8388608, 8388607, 16384, 40000, 0);
                4: configure(-5000, 7000, 32768, 300, 300);
                default: configure($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                                   $urandom, $urandom_range(8000), $urandom_range(8000));
            endcase
            directed();
            sent = 0;
            while (sent < 195) begin
                burst = $urandom_range(1, 30);
                repeat (burst) send_random();
                sent += burst;
                if (phase == 2 && sent > 100 && sent <= 130) hold_req = 1;
                if (phase == 5 && sent > 100 && sent <= 130) begin
                    i_valid <= 0;
                    wait_drained();
                end else
                    idle($urandom_range(3) == 0 ? 0 : $urandom_range(1, 6));
            end
        end
        idle(1);
        wait_drained();
        if (n_fail == 0)
            $display("PASS oriented_rectangle_overlap_check_unit");
        else
            $display("FAIL oriented_rectangle_overlap_check_unit");
        $finish;
    end

    initial begin
        #3ms;
        $display("FAIL oriented_rectangle_overlap_check_unit");
        $finish;
    end
endmodule
